// ----- hw/rtl/biquad_sample_filter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// biquad sample filter assertion macros
// shared concurrent assertion wrappers on clk and rst_n
// ----------------------------------------------------------------------------
`ifndef BIQUAD_SAMPLE_FILTER_UNIT_MACROS_SVH
`define BIQUAD_SAMPLE_FILTER_UNIT_MACROS_SVH

// checked only outside reset
`define BSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define BSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- hw/rtl/bsf_pkg.sv -----
// ----------------------------------------------------------------------------
// bsf_pkg
// widths, register indexes and fixed-point helpers of the biquad sample filter
// ----------------------------------------------------------------------------
`default_nettype none

package bsf_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int COEF_FRAC_BITS = 30;
  localparam int STATE_BITS     = 56;
  localparam int COEF_W         = 32;

  // recentered sample in half-lsb units
  localparam int X_W    = SAMPLE_BITS + 1;
  // state words go through the multiplier as a low and a high half
  localparam int SPLIT  = STATE_BITS / 2;
  localparam int HI_W   = STATE_BITS - SPLIT;
  localparam int OPA_W  = HI_W + 1;
  localparam int PROD_W = OPA_W + COEF_W;

  localparam int ACC_A1 = STATE_BITS + COEF_W;
  localparam int ACC_A2 = X_W + COEF_W + COEF_FRAC_BITS;
  localparam int ACC_A3 = STATE_BITS + COEF_FRAC_BITS + 1;
  localparam int ACC_M  = (ACC_A1 > ACC_A2) ? ACC_A1 : ACC_A2;
  localparam int ACC_W  = ((ACC_M > ACC_A3) ? ACC_M : ACC_A3) + 2;
  localparam int SH_W   = ACC_W - COEF_FRAC_BITS;

  localparam int T_B    = SAMPLE_BITS + COEF_FRAC_BITS + 1;
  localparam int T_W    = ((STATE_BITS > T_B) ? STATE_BITS : T_B) + 1;
  localparam int TT_W   = T_W - COEF_FRAC_BITS - 1;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_B0 = cfg_idx_t'(0);
  localparam cfg_idx_t REG_B1 = cfg_idx_t'(1);
  localparam cfg_idx_t REG_B2 = cfg_idx_t'(2);
  localparam cfg_idx_t REG_A1 = cfg_idx_t'(3);
  localparam cfg_idx_t REG_A2 = cfg_idx_t'(4);

  typedef enum logic [1:0] {
    OPA_X,
    OPA_YL,
    OPA_YH
  } opa_sel_t;

  typedef enum logic [1:0] {
    BASE_ACC,
    BASE_D1,
    BASE_D2,
    BASE_ZERO
  } acc_base_t;

  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_P_FRAC,
    SUB_P,
    SUB_P_SPLIT
  } acc_add_t;

  // floor by the fraction bits, then saturate to the state width
  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [ACC_W-1:0] a
  );
    logic [SH_W-1:0]            v;
    logic [SH_W-STATE_BITS:0]   top;
    logic signed [STATE_BITS-1:0] r;
    v   = a[ACC_W-1:COEF_FRAC_BITS];
    top = v[SH_W-1:STATE_BITS-1];
    if (top == '0 || top == '1) begin
      r = v[STATE_BITS-1:0];
    end else if (v[SH_W-1]) begin
      r = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // re-bias to a unipolar code and clamp
  function automatic logic [SAMPLE_BITS-1:0] dac_from_y(
    input logic signed [STATE_BITS-1:0] y
  );
    logic [T_W-1:0]         fs_sh;
    logic signed [T_W-1:0]  sum;
    logic [TT_W-1:0]        t;
    logic [SAMPLE_BITS-1:0] r;
    fs_sh = T_W'(FULL_SCALE) << COEF_FRAC_BITS;
    sum   = T_W'(y) + $signed(fs_sh);
    t     = sum[T_W-1:COEF_FRAC_BITS+1];
    if (t[TT_W-1]) begin
      r = '0;
    end else if (t > TT_W'(FULL_SCALE)) begin
      r = FULL_SCALE;
    end else begin
      r = t[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/biquad_sample_filter_unit.sv -----
// an accepted input word steps through xb0, xb1, y, yl1, yh1, xb2, yl2, yh2, fin1
//   and fin2 to out_valid, the steps set by seven products through the one
//   29 x 32 multiplier and the feedback products waiting on the saturated y
// new words enter only in idle, also while the last one waits in the output register
// reset: synchronous, active low; clears coefficients, both delays and the sequencer
// ----------------------------------------------------------------------------
// biquad_sample_filter_unit
// transposed direct-form-ii biquad from a 12-bit adc sample to a 12-bit dac code
// ----------------------------------------------------------------------------
`default_nettype none

`include "biquad_sample_filter_unit_macros.svh"

module biquad_sample_filter_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bsf_pkg::SAMPLE_BITS-1:0]  in_adc_sample,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [bsf_pkg::SAMPLE_BITS-1:0]       out_dac_code,
  input  wire logic                             cfg_we,
  input  wire logic [bsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bsf_pkg::COEF_W-1:0]       cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_XB0,
    S_XB1,
    S_Y,
    S_YL1,
    S_YH1,
    S_XB2,
    S_YL2,
    S_YH2,
    S_FIN1,
    S_FIN2
  } state_t;

  state_t state_r, state_nxt;

  logic signed [bsf_pkg::COEF_W-1:0]     b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [bsf_pkg::COEF_W-1:0]     b0_nxt, b1_nxt, b2_nxt, a1_nxt, a2_nxt;
  logic signed [bsf_pkg::X_W-1:0]        x_r, x_nxt;
  logic signed [bsf_pkg::STATE_BITS-1:0] y_r, y_nxt;
  logic signed [bsf_pkg::STATE_BITS-1:0] d1_r, d1_nxt;
  logic signed [bsf_pkg::STATE_BITS-1:0] d2_r, d2_nxt;
  logic signed [bsf_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic signed [bsf_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [bsf_pkg::SAMPLE_BITS-1:0]       dac_r, dac_nxt;

  bsf_pkg::opa_sel_t                     opa_sel;
  bsf_pkg::cfg_idx_t                     coef_sel;
  bsf_pkg::acc_base_t                    acc_base;
  bsf_pkg::acc_add_t                     acc_add;

  logic signed [bsf_pkg::OPA_W-1:0]      mul_a;
  logic signed [bsf_pkg::COEF_W-1:0]     mul_b;
  logic signed [bsf_pkg::ACC_W-1:0]      p_ext;
  logic signed [bsf_pkg::ACC_W-1:0]      base_val;
  logic signed [bsf_pkg::ACC_W-1:0]      add_val;
  logic                                  accept;
  logic                                  out_free;

  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_dac_code = dac_r;

  // step decode: multiplier operands and what the accumulator does with the
  // product registered in the previous step
  always_comb begin
    opa_sel  = bsf_pkg::OPA_X;
    coef_sel = bsf_pkg::REG_B0;
    acc_base = bsf_pkg::BASE_ACC;
    acc_add  = bsf_pkg::ADD_NONE;
    case (state_r)
      S_XB0: begin
        acc_base = bsf_pkg::BASE_D1;
      end
      S_XB1: begin
        coef_sel = bsf_pkg::REG_B1;
        acc_add  = bsf_pkg::ADD_P_FRAC;
      end
      S_Y: begin
        acc_base = bsf_pkg::BASE_D2;
        acc_add  = bsf_pkg::ADD_P_FRAC;
      end
      S_YL1: begin
        opa_sel  = bsf_pkg::OPA_YL;
        coef_sel = bsf_pkg::REG_A1;
      end
      S_YH1: begin
        opa_sel  = bsf_pkg::OPA_YH;
        coef_sel = bsf_pkg::REG_A1;
        acc_add  = bsf_pkg::SUB_P;
      end
      S_XB2: begin
        coef_sel = bsf_pkg::REG_B2;
        acc_add  = bsf_pkg::SUB_P_SPLIT;
      end
      S_YL2: begin
        opa_sel  = bsf_pkg::OPA_YL;
        coef_sel = bsf_pkg::REG_A2;
        acc_base = bsf_pkg::BASE_ZERO;
        acc_add  = bsf_pkg::ADD_P_FRAC;
      end
      S_YH2: begin
        opa_sel  = bsf_pkg::OPA_YH;
        coef_sel = bsf_pkg::REG_A2;
        acc_add  = bsf_pkg::SUB_P;
      end
      S_FIN1: begin
        acc_add  = bsf_pkg::SUB_P_SPLIT;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (opa_sel)
      bsf_pkg::OPA_YL: mul_a = $signed(bsf_pkg::OPA_W'({1'b0, y_r[bsf_pkg::SPLIT-1:0]}));
      bsf_pkg::OPA_YH: mul_a = bsf_pkg::OPA_W'($signed(
                                 y_r[bsf_pkg::STATE_BITS-1:bsf_pkg::SPLIT]));
      default:         mul_a = bsf_pkg::OPA_W'(x_r);
    endcase
    case (coef_sel)
      bsf_pkg::REG_B1: mul_b = b1_r;
      bsf_pkg::REG_B2: mul_b = b2_r;
      bsf_pkg::REG_A1: mul_b = a1_r;
      bsf_pkg::REG_A2: mul_b = a2_r;
      default:         mul_b = b0_r;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign p_ext    = bsf_pkg::ACC_W'(prod_r);

  always_comb begin
    case (acc_base)
      bsf_pkg::BASE_D1:   base_val = bsf_pkg::ACC_W'(d1_r) <<< bsf_pkg::COEF_FRAC_BITS;
      bsf_pkg::BASE_D2:   base_val = bsf_pkg::ACC_W'(d2_r) <<< bsf_pkg::COEF_FRAC_BITS;
      bsf_pkg::BASE_ZERO: base_val = '0;
      default:            base_val = acc_r;
    endcase
    case (acc_add)
      bsf_pkg::ADD_P_FRAC:  add_val = p_ext <<< bsf_pkg::COEF_FRAC_BITS;
      bsf_pkg::SUB_P:       add_val = -p_ext;
      bsf_pkg::SUB_P_SPLIT: add_val = -(p_ext <<< bsf_pkg::SPLIT);
      default:              add_val = '0;
    endcase
    acc_nxt = base_val + add_val;
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    dac_nxt       = dac_r;
    out_valid_nxt = out_valid_r;
    b0_nxt        = b0_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    a1_nxt        = a1_r;
    a2_nxt        = a2_r;

    if (cfg_we) begin
      case (cfg_index)
        bsf_pkg::REG_B0: b0_nxt = cfg_wdata;
        bsf_pkg::REG_B1: b1_nxt = cfg_wdata;
        bsf_pkg::REG_B2: b2_nxt = cfg_wdata;
        bsf_pkg::REG_A1: a1_nxt = cfg_wdata;
        bsf_pkg::REG_A2: a2_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // 2*raw - full scale, exact in the signed width
          x_nxt     = {in_adc_sample, 1'b0} - bsf_pkg::X_W'(bsf_pkg::FULL_SCALE);
          state_nxt = S_XB0;
        end
      end
      S_XB0:  state_nxt = S_XB1;
      S_XB1:  state_nxt = S_Y;
      S_Y: begin
        y_nxt     = bsf_pkg::sat_state(acc_r);
        state_nxt = S_YL1;
      end
      S_YL1:  state_nxt = S_YH1;
      S_YH1:  state_nxt = S_XB2;
      S_XB2:  state_nxt = S_YL2;
      S_YL2: begin
        d1_nxt    = bsf_pkg::sat_state(acc_r);
        state_nxt = S_YH2;
      end
      S_YH2:  state_nxt = S_FIN1;
      S_FIN1: state_nxt = S_FIN2;
      S_FIN2: begin
        // hold here until the output register is free
        if (out_free) begin
          d2_nxt        = bsf_pkg::sat_state(acc_r);
          dac_nxt       = bsf_pkg::dac_from_y(y_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      d1_r        <= '0;
      d2_r        <= '0;
      b0_r        <= '0;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      d1_r        <= d1_nxt;
      d2_r        <= d2_nxt;
      b0_r        <= b0_nxt;
      b1_r        <= b1_nxt;
      b2_r        <= b2_nxt;
      a1_r        <= a1_nxt;
      a2_r        <= a2_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    acc_r  <= (state_r == S_FIN2) ? acc_r : acc_nxt;
    prod_r <= prod_nxt;
    dac_r  <= dac_nxt;
  end

  `BSF_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> (state_r == S_IDLE && !out_valid_r), "reset did not idle the sequencer")
  `BSF_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_r == S_XB0), "accepted word did not start the sequence")
  `BSF_ASSERT(a_out_from_last, $rose(out_valid_r) |-> $past(state_r == S_FIN2), "result word appeared outside the last step")
  `BSF_ASSERT(a_d1_one_step, ($past(rst_n) && !$stable(d1_r)) |-> $past(state_r == S_YL2), "first delay changed outside its update step")
  `BSF_ASSERT(a_d2_one_step, ($past(rst_n) && !$stable(d2_r)) |-> $past(state_r == S_FIN2 && out_free), "second delay changed outside its update step")

endmodule

`default_nettype wire

// ----- tb/bsf_dac_checker.sv -----
// ----------------------------------------------------------------------------
// bsf_dac_checker
// watches the sample and code channels and the coefficient port, predicts each
// dac code from its own copy of the biquad state and compares in order
// ----------------------------------------------------------------------------
module bsf_dac_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [bsf_pkg::SAMPLE_BITS-1:0] in_adc_sample,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [bsf_pkg::SAMPLE_BITS-1:0] out_dac_code,
  input  logic                            cfg_we,
  input  logic [bsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsf_pkg::COEF_W-1:0]      cfg_wdata,
  output int unsigned                     pending_words,
  output int unsigned                     checked_words,
  output int unsigned                     mismatch_count
);
  import bsf_pkg::*;

  localparam int WIDE = 128;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] code;
  } dac_expect_t;

  dac_expect_t expected_codes [$];

  logic signed [COEF_W-1:0]     coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [STATE_BITS-1:0] delay_one, delay_two;

  initial begin
    pending_words  = 0;
    checked_words  = 0;
    mismatch_count = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // saturate to the signed state width
  function automatic logic signed [STATE_BITS-1:0] clip_state(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] top_lim, bot_lim;
    top_lim = (128'sd1 <<< (STATE_BITS - 1)) - 128'sd1;
    bot_lim = -(128'sd1 <<< (STATE_BITS - 1));
    if (v > top_lim) begin
      v = top_lim;
    end else if (v < bot_lim) begin
      v = bot_lim;
    end
    return v[STATE_BITS-1:0];
  endfunction

  // one biquad step; advances both delays and returns the dac code
  function automatic logic [SAMPLE_BITS-1:0] predict_dac_code(input logic [SAMPLE_BITS-1:0] raw);
    logic signed [WIDE-1:0] fs, xw, yw, d1w, d2w, acc, t;
    logic signed [WIDE-1:0] b0w, b1w, b2w, a1w, a2w;
    logic signed [STATE_BITS-1:0] y;
    fs  = (128'sd1 <<< SAMPLE_BITS) - 128'sd1;
    xw  = WIDE'(raw);
    xw  = (xw <<< 1) - fs;
    b0w = coef_b0;
    b1w = coef_b1;
    b2w = coef_b2;
    a1w = coef_a1;
    a2w = coef_a2;
    d1w = delay_one;
    d2w = delay_two;

    y  = clip_state(xw * b0w + d1w);
    yw = y;

    acc = ((xw * b1w) <<< COEF_FRAC_BITS) - yw * a1w + (d2w <<< COEF_FRAC_BITS);
    delay_one = clip_state(acc >>> COEF_FRAC_BITS);
    acc = ((xw * b2w) <<< COEF_FRAC_BITS) - yw * a2w;
    delay_two = clip_state(acc >>> COEF_FRAC_BITS);

    // re-bias by full scale, halve, clamp to the code range
    t = (yw + (fs <<< COEF_FRAC_BITS)) >>> (COEF_FRAC_BITS + 1);
    if (t < 0) begin
      return '0;
    end else if (t > fs) begin
      return FULL_SCALE;
    end
    return t[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk) begin : watch
    dac_expect_t item;
    if (!rst_n) begin
      coef_b0   = '0;
      coef_b1   = '0;
      coef_b2   = '0;
      coef_a1   = '0;
      coef_a2   = '0;
      delay_one = '0;
      delay_two = '0;
      expected_codes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_B0:  coef_b0 = cfg_wdata;
          REG_B1:  coef_b1 = cfg_wdata;
          REG_B2:  coef_b2 = cfg_wdata;
          REG_A1:  coef_a1 = cfg_wdata;
          REG_A2:  coef_a2 = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        item.sample = in_adc_sample;
        item.code   = predict_dac_code(in_adc_sample);
        expected_codes.push_back(item);
      end
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          flag_mismatch($sformatf("dac word %0d with no sample pending", out_dac_code));
        end else begin
          item = expected_codes.pop_front();
          checked_words <= checked_words + 1;
          if (out_dac_code !== item.code) begin
            flag_mismatch($sformatf("dac_code got %0d want %0d for sample %0d",
                                    out_dac_code, item.code, item.sample));
          end
        end
      end
    end
    pending_words <= expected_codes.size();
  end

endmodule

// ----- tb/tb_biquad_sample_filter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_biquad_sample_filter_unit
// drives adc samples and coefficient sets into the biquad with random gaps and
// output stalls; a checker beside the block predicts every dac code
// ----------------------------------------------------------------------------
module tb_biquad_sample_filter_unit;
  import bsf_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 24;
  localparam int IDLE_PCT      = 11;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 40;
  localparam int CALM_PHASE    = 5;
  localparam int PAUSE_PHASE   = 2;

  localparam cfg_idx_t REG_SPARE_FIRST = cfg_idx_t'(REG_A2 + 1);
  localparam cfg_idx_t REG_SPARE_LAST  = '1;

  localparam logic [COEF_W-1:0] COEF_ZERO    = '0;
  localparam logic [COEF_W-1:0] COEF_ONE     = 32'h4000_0000;
  localparam logic [COEF_W-1:0] COEF_NEG_ONE = 32'hC000_0000;
  localparam logic [COEF_W-1:0] COEF_MAX     = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN     = 32'h8000_0000;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_adc_sample = '0;
  logic                   out_valid;
  logic                   out_ready     = 1'b0;
  logic [SAMPLE_BITS-1:0] out_dac_code;
  logic                   cfg_we        = 1'b0;
  cfg_idx_t               cfg_index     = REG_B0;
  logic [COEF_W-1:0]      cfg_wdata     = '0;

  int unsigned pending_words, checked_words, mismatch_count;
  int unsigned quiet_cycles = 0;
  int unsigned samples_sent = 0;
  int unsigned coef_sets    = 0;
  logic        calm         = 1'b0;

  always #2 clk = ~clk;

  biquad_sample_filter_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_dac_code  (out_dac_code),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  bsf_dac_checker dac_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_adc_sample  (in_adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dac_code   (out_dac_code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .pending_words  (pending_words),
    .checked_words  (checked_words),
    .mismatch_count (mismatch_count)
  );

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // any word moved or register written counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("no progress for %0d cycles, pending %0d", QUIET_LIMIT, pending_words);
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_adc_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  // hold the sender until every predicted code has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, b1, b2, a1, a2);
    logic [COEF_W-1:0] vals [5];
    cfg_idx_t          regs [5];
    vals = '{b0, b1, b2, a1, a2};
    regs = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};
    for (int k = 0; k < 5; k++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= vals[k];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    coef_sets++;
  endtask

  // writes to unmapped indexes must leave the filter alone
  task automatic poke_spare_regs();
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= $urandom();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // poles inside the stability triangle, taps within +-1.0
  task automatic pick_stable_coefs(output logic [COEF_W-1:0] b0, b1, b2, a1, a2);
    longint one, p2, lim;
    one = longint'(COEF_ONE);
    p2  = (longint'($urandom_range(0, 1870)) - 922) * one / 1024;
    lim = (one + p2) * 63 / 64;
    a2  = COEF_W'(p2);
    a1  = COEF_W'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
    b0  = COEF_W'(longint'($urandom_range(0, 32'(2 * one))) - one);
    b1  = COEF_W'(longint'($urandom_range(0, 32'(2 * one))) - one);
    b2  = COEF_W'(longint'($urandom_range(0, 32'(2 * one))) - one);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] last);
    int r, v;
    r = $urandom_range(99);
    if (r < 60) begin
      return SAMPLE_BITS'($urandom_range(0, int'(FULL_SCALE)));
    end else if (r < 75) begin
      return $urandom_range(1) ? FULL_SCALE : '0;
    end
    // slow wander around the previous sample
    v = int'(last) + int'($urandom_range(0, 64)) - 32;
    if (v < 0) v = 0;
    if (v > int'(FULL_SCALE)) v = int'(FULL_SCALE);
    return SAMPLE_BITS'(v);
  endfunction

  initial begin : stimulus
    logic [COEF_W-1:0]      b0, b1, b2, a1, a2;
    logic [SAMPLE_BITS-1:0] last;
    last = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // coefficients straight out of reset: mid-scale code
    push_sample('0);
    push_sample(FULL_SCALE);

    // unity gain passes the sample through
    settle();
    load_coefs(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    poke_spare_regs();
    push_sample('0);
    push_sample(FULL_SCALE);
    push_sample(12'd2047);
    push_sample(12'd2048);
    push_sample(12'd1);
    push_sample(12'd4094);
    push_sample(12'hAAA);
    push_sample(12'h555);

    // inversion
    settle();
    load_coefs(COEF_NEG_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    push_sample('0);
    push_sample(FULL_SCALE);
    push_sample(12'd1000);

    // largest taps everywhere: y runs past the code range, codes clamp
    settle();
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    push_sample(FULL_SCALE);
    push_sample('0);
    push_sample(FULL_SCALE);
    push_sample('0);
    push_sample(FULL_SCALE);

    settle();
    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    push_sample('0);
    push_sample(FULL_SCALE);
    push_sample('0);
    push_sample(FULL_SCALE);

    // delays left by the last set drain through zero taps
    settle();
    load_coefs(COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    push_sample(12'd2047);
    push_sample(12'd2048);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if (phase % 4 == 3) begin
        load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        pick_stable_coefs(b0, b1, b2, a1, a2);
        load_coefs(b0, b1, b2, a1, a2);
      end
      if (phase % 3 == 1) begin
        poke_spare_regs();
      end
      calm = (phase == CALM_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == PAUSE_PHASE && i == PHASE_ITEMS / 2) begin
          settle();
        end
        last = pick_sample(last);
        push_sample(last);
      end
    end
    calm = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples over %0d coefficient sets", samples_sent, coef_sets);
    $display("sets include unity, inversion, extreme taps, stable and arbitrary filters");
    $display("codes compared: %0d, mismatches: %0d", checked_words, mismatch_count);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
